### sv/vn3_pkg.sv
// Package: constants and small helpers for the 3D value noise unit.
`default_nettype none
package vn3_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] HK_A0 = 32'd453415497;
  localparam logic [31:0] HK_A1 = 32'd692345763;
  localparam logic [31:0] HK_A2 = 32'd473546769;
  localparam logic [31:0] HK_B0 = 32'd213452313;
  localparam logic [31:0] HK_B1 = 32'd685246969;
  localparam logic [31:0] HK_B2 = 32'd743457661;
  localparam logic [31:0] HK_C0 = 32'd915876951;
  localparam logic [31:0] HK_C1 = 32'd456766761;
  localparam logic [31:0] HK_C2 = 32'd421345463;
  localparam logic [31:0] HK_D0 = 32'd584278733;
  localparam logic [31:0] HK_D1 = 32'd543588311;
  localparam logic [31:0] HK_D2 = 32'd943566311;
  // register index (byte address bit 2)
  localparam logic [0:0] ADDR_COMBINE_MODE = 1'b0;
endpackage
`default_nettype wire

### sv/vn3_lookup.sv
// One value noise lookup: stalled pipeline of hash, smoothstep and blend stages.
`default_nettype none
module vn3_lookup
  import vn3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  input  wire logic [31:0] z,
  output logic      [15:0] result
);
  // stage 1: cell and fraction
  logic [31:0] ci [3];
  logic [31:0] c1 [3];
  logic [15:0] fr [3];
  logic [31:0] sq1 [3];
  logic [31:0] pa [8][9];
  logic [31:0] ha [8][3];
  logic [31:0] pd [8][3];
  logic [15:0] cv [8];
  logic [15:0] e [4];
  logic [15:0] f [2];
  logic [15:0] ev [4];
  logic [15:0] fv [2];
  logic [15:0] w_y3, w_x3, w_x4;
  logic [32:0] sw [3];

  function automatic logic [15:0] frac16(input logic [31:0] u);
    logic [31:0] m;
    m = u & ((32'd1 << FRAC_BITS) - 32'd1);
    if (FRAC_BITS >= 16) frac16 = 16'(m >> (FRAC_BITS - 16));
    else frac16 = 16'(m << (16 - FRAC_BITS));
  endfunction

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] wt);
    logic [33:0] r;
    r = 34'(a) * (34'(17'h10000) - 34'(wt)) + 34'(b) * 34'(wt);
    blend = r[31:16];
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ci[k] = 32'($signed(k == 0 ? x : (k == 1 ? y : z)) >>> FRAC_BITS);
      fr[k] = frac16(k == 0 ? x : (k == 1 ? y : z));
    end
  end

  // stage 1 regs
  logic [31:0] r1_c [3];
  logic [15:0] r1_t [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        r1_c[k] <= ci[k];
        r1_t[k] <= fr[k];
      end
    end
  end

  // stage 2: t^2 and first-round hash products per corner
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c1[k] = r1_c[k] + 32'd1;
      sq1[k] = 32'(r1_t[k]) * 32'(r1_t[k]);
    end
    for (int n = 0; n < 8; n++) begin
      logic [31:0] cx, cy, cz;
      cx = n[2] ? c1[0] : r1_c[0];
      cy = n[1] ? c1[1] : r1_c[1];
      cz = n[0] ? c1[2] : r1_c[2];
      pa[n][0] = cx * HK_A0; pa[n][1] = cy * HK_A1; pa[n][2] = cz * HK_A2;
      pa[n][3] = cy * HK_B0; pa[n][4] = cz * HK_B1; pa[n][5] = cx * HK_B2;
      pa[n][6] = cz * HK_C0; pa[n][7] = cx * HK_C1; pa[n][8] = cy * HK_C2;
    end
  end

  logic [31:0] r2_p [8][9];
  logic [15:0] r2_t [3];
  logic [15:0] r2_sq [3];
  always_ff @(posedge clk) begin
    if (en) begin
      r2_p <= pa;
      for (int k = 0; k < 3; k++) begin
        r2_t[k] <= r1_t[k];
        r2_sq[k] <= sq1[k][31:16];
      end
    end
  end

  // stage 3: combine first round; smoothstep product
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      ha[n][0] = (r2_p[n][0] + r2_p[n][1]) ^ r2_p[n][2];
      ha[n][1] = (r2_p[n][3] + r2_p[n][4]) ^ r2_p[n][5];
      ha[n][2] = (r2_p[n][6] + r2_p[n][7]) ^ r2_p[n][8];
    end
    for (int k = 0; k < 3; k++) begin
      sw[k] = 33'(r2_sq[k]) * (33'(18'd196608) - 33'({r2_t[k], 1'b0}));
    end
  end

  logic [31:0] r3_h [8][3];
  logic [15:0] r3_w [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 8; n++)
        for (int j = 0; j < 3; j++) r3_h[n][j] <= ha[n][j];
      for (int k = 0; k < 3; k++)
        r3_w[k] <= (|sw[k][32:32]) ? 16'hFFFF : sw[k][31:16];
    end
  end

  // stage 4: second-round products
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      pd[n][0] = r3_h[n][0] * HK_D0;
      pd[n][1] = r3_h[n][1] * HK_D1;
      pd[n][2] = r3_h[n][2] * HK_D2;
    end
  end

  logic [31:0] r4_p [8][3];
  logic [15:0] r4_w [3];
  always_ff @(posedge clk) begin
    if (en) begin
      r4_p <= pd;
      r4_w <= r3_w;
    end
  end

  // stage 5: corner values and z blend
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      logic [31:0] d;
      d = (r4_p[n][0] + r4_p[n][1]) ^ r4_p[n][2];
      cv[n] = d[25:10];
    end
    for (int m = 0; m < 4; m++) e[m] = blend(cv[2*m], cv[2*m+1], r4_w[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ev <= e;
      w_y3 <= r4_w[1];
      w_x3 <= r4_w[0];
    end
  end

  // stage 6: y blend
  always_comb begin
    f[0] = blend(ev[0], ev[1], w_y3);
    f[1] = blend(ev[2], ev[3], w_y3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fv <= f;
      w_x4 <= w_x3;
    end
  end

  // stage 7: x blend
  always_ff @(posedge clk) begin
    if (en) result <= blend(fv[0], fv[1], w_x4);
  end

  logic unused;
  assign unused = rst;
endmodule
`default_nettype wire

### sv/value_noise_3d_unit.sv
// Top level: 3D value noise unit with plain and averaged modes.
//  channel | signals                           | dir
//  in      | in_valid, in_stall, x/y/z_coord   | in
//  out     | out_valid, out_stall, noise_value | out
//  cfg     | APB psel..prdata                  | in/out
// An accepted word passes the lookup stages, then the average, square and result
// registers to noise_value, one word per cycle while no stall holds the pipeline.
// Depth set by the two hash multiply rounds, the three blends and the final smoothstep.
// Reset clears valid bits and combine_mode. A stall freezes the whole
// pipeline; in_stall follows out_stall only when the last stage is full.
`default_nettype none
module value_noise_3d_unit
  import vn3_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_coord,
  input  wire logic [31:0] z_coord,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] noise_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int LAT = 7;
  localparam int DEPTH = LAT + 3;
  localparam logic [31:0] OFF = 32'd201 << (FRAC_BITS - 1);

  logic combine_mode;
  logic en;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] mode_p;
  logic [15:0] r_a, r_b;
  logic [16:0] sum;
  logic [15:0] avg;
  logic [31:0] sm_sq;
  logic [15:0] sm_sqh, sm_t2;
  logic [32:0] sm_p;
  logic [15:0] plain_d1, plain_d2, res;

  assign pready = 1'b1;
  assign en = !(vld[DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];
  assign noise_value = res;
  assign prdata = {31'd0, combine_mode};

  always_ff @(posedge clk) begin
    if (rst) combine_mode <= 1'b0;
    else if (psel && penable && pwrite && paddr[2:2] == ADDR_COMBINE_MODE)
      combine_mode <= pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) mode_p <= {mode_p[DEPTH-2:0], combine_mode};
  end

  vn3_lookup #(.FRAC_BITS(FRAC_BITS)) u_la (
    .clk(clk), .rst(rst), .en(en), .x(x_coord), .y(y_coord), .z(z_coord), .result(r_a));
  vn3_lookup #(.FRAC_BITS(FRAC_BITS)) u_lb (
    .clk(clk), .rst(rst), .en(en), .x(x_coord + OFF), .y(z_coord + OFF),
    .z(y_coord + OFF), .result(r_b));

  // final smoothstep over the average, three stages
  assign sum = 17'(r_a) + 17'(r_b);
  assign sm_sq = 32'(avg) * 32'(avg);
  assign sm_p = 33'(sm_sqh) * (33'(18'd196608) - 33'({sm_t2, 1'b0}));

  always_ff @(posedge clk) begin
    if (en) begin
      avg <= sum[16:1];
      plain_d1 <= r_a;
      sm_sqh <= sm_sq[31:16];
      sm_t2 <= avg;
      plain_d2 <= plain_d1;
      if (mode_p[DEPTH-2])
        res <= sm_p[32] ? 16'hFFFF : sm_p[31:16];
      else
        res <= plain_d2;
    end
  end

  logic unused;
  assign unused = (|pwdata[31:1]) ^ (|paddr[1:0]) ^ mode_p[DEPTH-1];
endmodule
`default_nettype wire
